// ===== rtl/dhf_pkg.sv =====
// Shared constants, register indexes and the reciprocal table for the
// 3x3 depth hole filler. No dependencies.
package dhf_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_FRAME   = 3;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int DEPTH_W     = 16;
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int MINN_W      = 4;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = DEPTH_W + 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_HOLE_VALUE    = 2'd2,
    CFG_MIN_NEIGHBORS = 2'd3
  } cfg_idx_t;

  // ceil(2^24 / d): exact floor(n / d) for n < 2^19 and d in 1..8
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      4'd1:    m = RECIP_W'(16777216);
      4'd2:    m = RECIP_W'(8388608);
      4'd3:    m = RECIP_W'(5592406);
      4'd4:    m = RECIP_W'(4194304);
      4'd5:    m = RECIP_W'(3355444);
      4'd6:    m = RECIP_W'(2796203);
      4'd7:    m = RECIP_W'(2396746);
      4'd8:    m = RECIP_W'(2097152);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/dhf_in_if.sv =====
// Input pixel channel: valid/ready handshake carrying one depth word.
// Depends on dhf_pkg.
interface dhf_in_if import dhf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_in;

  modport source (output valid, output depth_in, input ready);
  modport sink   (input valid, input depth_in, output ready);
endinterface

// ===== rtl/dhf_out_if.sv =====
// Result channel: valid/ready handshake carrying an addressed depth word.
// Depends on dhf_pkg.
interface dhf_out_if import dhf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [DEPTH_W-1:0] depth_out;
  logic               last_of_run;

  modport source (output valid, output out_row, output out_col, output depth_out,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input depth_out,
                  input last_of_run, output ready);
endinterface

// ===== rtl/depth_hole_fill_3x3.sv =====
// Streaming 3x3 hole filler for 16-bit depth images.
// Depends on dhf_pkg, dhf_in_if, dhf_out_if and dhf_ram.
//
// Usage:
//   pixels  : raster-order depth words, valid/ready. One word is taken at a
//             time; ready is high only while the block is idle.
//   results : addressed output words (row, column, depth, last_of_run).
//             A border pixel comes back unchanged when it arrives; interior
//             pixel (r-1,c-1) comes back when pixel (r,c) arrives, filled with
//             the truncated mean of its non-hole neighbors if it is a hole and
//             enough neighbors are valid. Up to two words per input word,
//             interior first; last_of_run marks the final one.
//   cfg     : write enable, register index, data; write only while idle.
// Sequence: read both line RAMs, sum neighbors, multiply by reciprocal,
//   write back (plus a second line RAM write on the last column), then
//   present the result words in turn, interior first.
// Reset: position counters go to row 0, column 0 and registers take their
//   reset values; line RAM contents stay undefined until written.
// Stall: a result word holds on the port until taken; no new input word is
//   accepted until every result word of the current one has been taken.
module depth_hole_fill_3x3 import dhf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dhf_in_if.sink                pixels,
  dhf_out_if.source             results
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUM   = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_WB    = 7'b0001000,
    ST_FIX   = 7'b0010000,
    ST_OUT_I = 7'b0100000,
    ST_OUT_B = 7'b1000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [FW_W-1:0]    frame_width;
  logic [FH_W-1:0]    frame_height;
  logic [DEPTH_W-1:0] hole_value;
  logic [MINN_W-1:0]  min_neighbors;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_W'(320);
      frame_height  <= FH_W'(240);
      hole_value    <= '1;
      min_neighbors <= MINN_W'(5);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[FH_W-1:0];
        CFG_HOLE_VALUE:    hole_value    <= cfg_data[DEPTH_W-1:0];
        CFG_MIN_NEIGHBORS: min_neighbors <= cfg_data[MINN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  always_comb begin
    if (frame_width < FW_W'(MIN_FRAME))       w_eff = FW_W'(MIN_FRAME);
    else if (frame_width > FW_W'(MAX_WIDTH))  w_eff = FW_W'(MAX_WIDTH);
    else                                      w_eff = frame_width;
    if (frame_height < FH_W'(MIN_FRAME))      h_eff = FH_W'(MIN_FRAME);
    else if (frame_height > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
    else                                      h_eff = frame_height;
  end

  // position of the arriving pixel, with wrap for a shrunken geometry
  logic [ROW_W-1:0] row_count, cur_row;
  logic [COL_W-1:0] col_count, cur_col;
  logic             col_wrap, col_last, row_last;
  logic [FH_W-1:0]  row_step;

  always_comb begin
    col_wrap = FW_W'(col_count) >= w_eff;
    row_step = FH_W'(row_count) + FH_W'(col_wrap);
    cur_col  = col_wrap ? '0 : col_count;
    cur_row  = (row_step >= h_eff) ? '0 : row_step[ROW_W-1:0];
    col_last = (FW_W'(cur_col) + FW_W'(1)) >= w_eff;
    row_last = (FH_W'(cur_row) + FH_W'(1)) >= h_eff;
  end

  logic accept;
  assign accept       = pixels.valid && pixels.ready;
  assign pixels.ready = (state == ST_IDLE);

  // per-word registers
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [DEPTH_W-1:0] din_q;
  logic               interior_q, border_q, lastcol_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= row_last ? '0 : cur_row + ROW_W'(1);
      end else begin
        col_count <= cur_col + COL_W'(1);
        row_count <= cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q      <= cur_row;
      col_q      <= cur_col;
      din_q      <= pixels.depth_in;
      interior_q <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      border_q   <= (cur_row == '0) || row_last || (cur_col == '0) || col_last;
      lastcol_q  <= col_last;
    end
  end

  // line RAMs: row r-2 (final values) and row r-1 (raw values)
  logic               laa_we, la_we;
  logic [COL_W-1:0]   laa_waddr;
  logic [DEPTH_W-1:0] laa_wdata;
  logic [DEPTH_W-1:0] laa_rdata, la_rdata;

  dhf_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_WIDTH)) u_line_above_above (
    .clk   (clk),
    .we    (laa_we),
    .waddr (laa_waddr),
    .wdata (laa_wdata),
    .raddr (cur_col),
    .rdata (laa_rdata)
  );

  dhf_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (la_we),
    .waddr (col_q),
    .wdata (din_q),
    .raddr (cur_col),
    .rdata (la_rdata)
  );

  // window: index 2*row + k, k=0 column c-2, k=1 column c-1
  logic [DEPTH_W-1:0] win [6];
  logic [DEPTH_W-1:0] top_q, mid_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               fill_q;
  logic [PROD_W-1:0]  prod_q;
  logic [DEPTH_W-1:0] fv, fv_q;

  // neighbor count and sum, straight from the RAM read data; adder tree
  logic [DEPTH_W-1:0] nb [8];
  logic [7:0]         nb_ok;
  logic [SUM_W-1:0]   nb_val [8];
  logic [SUM_W-1:0]   nb_sum;
  logic [CNT_W-1:0]   nb_cnt;

  always_comb begin
    nb[0] = win[0];
    nb[1] = win[1];
    nb[2] = laa_rdata;
    nb[3] = win[2];
    nb[4] = la_rdata;
    nb[5] = win[4];
    nb[6] = win[5];
    nb[7] = din_q;
    for (int i = 0; i < 8; i++) begin
      nb_ok[i]  = (nb[i] != hole_value);
      nb_val[i] = nb_ok[i] ? SUM_W'(nb[i]) : '0;
    end
    nb_sum = ((nb_val[0] + nb_val[1]) + (nb_val[2] + nb_val[3])) +
             ((nb_val[4] + nb_val[5]) + (nb_val[6] + nb_val[7]));
    nb_cnt = CNT_W'($countones(nb_ok));
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      top_q  <= laa_rdata;
      mid_q  <= la_rdata;
      sum_q  <= nb_sum;
      cnt_q  <= nb_cnt;
      fill_q <= interior_q && (win[3] == hole_value) && (nb_cnt != '0) &&
                (nb_cnt >= min_neighbors);
    end
    if (state == ST_MUL) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(recip(cnt_q));
    end
  end

  // final value of pixel (r-1, c-1)
  assign fv = fill_q ? prod_q[RECIP_SHIFT +: DEPTH_W] : win[3];

  always_ff @(posedge clk) begin
    if (state == ST_WB) begin
      fv_q   <= fv;
      win[0] <= win[1];
      win[1] <= top_q;
      win[2] <= fv;
      win[3] <= mid_q;
      win[4] <= win[5];
      win[5] <= din_q;
    end
  end

  // write-back: raw pixel to the row r-1 RAM, final value to column c-1
  // of the r-2 RAM; last column: raw upper pixel to column c in ST_FIX
  always_comb begin
    la_we     = (state == ST_WB);
    laa_we    = ((state == ST_WB) && (col_q != '0)) || (state == ST_FIX);
    laa_waddr = (state == ST_FIX) ? col_q : col_q - COL_W'(1);
    laa_wdata = (state == ST_FIX) ? mid_q : fv;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SUM;
      ST_SUM:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_WB;
      ST_WB: begin
        if (lastcol_q)       state_next = ST_FIX;
        else if (interior_q) state_next = ST_OUT_I;
        else if (border_q)   state_next = ST_OUT_B;
        else                 state_next = ST_IDLE;
      end
      ST_FIX: begin
        if (interior_q)      state_next = ST_OUT_I;
        else                 state_next = ST_OUT_B;
      end
      ST_OUT_I: begin
        if (results.ready) state_next = border_q ? ST_OUT_B : ST_IDLE;
      end
      ST_OUT_B: begin
        if (results.ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result word: interior pixel first, then the border pixel
  always_comb begin
    results.valid       = (state == ST_OUT_I) || (state == ST_OUT_B);
    results.out_row     = (state == ST_OUT_I) ? row_q - ROW_W'(1) : row_q;
    results.out_col     = (state == ST_OUT_I) ? col_q - COL_W'(1) : col_q;
    results.depth_out   = (state == ST_OUT_I) ? fv_q : din_q;
    results.last_of_run = (state == ST_OUT_B) || !border_q;
  end

  // no input word is taken while a result word is pending
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !pixels.ready)
    else $error("input accepted while a result word is pending");

  // line RAMs are written only in the write-back cycles
  a_ram_write_window: assert property (@(posedge clk) disable iff (rst)
    (laa_we || la_we) |-> (state == ST_WB || state == ST_FIX))
    else $error("line RAM written outside write-back");

  // a fill always has at least one valid neighbor to divide by
  a_fill_has_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && fill_q) |-> (cnt_q != '0 && cnt_q <= CNT_W'(8)))
    else $error("fill with an empty neighbor count");

  // an interior result is followed by the border result of the same word
  a_border_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_I && results.ready && border_q) |=> state == ST_OUT_B)
    else $error("border word lost after interior word");

  // the last column always takes the extra write-back cycle
  a_lastcol_fix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB && lastcol_q) |=> state == ST_FIX)
    else $error("last column skipped second line RAM write");

endmodule

// ===== rtl/dhf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sim/dhf_fill_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for depth_hole_fill_3x3: tracks the raster position, line buffers
// and window of the filler, predicts every result word and compares it.
// Depends on dhf_pkg, dhf_in_if and dhf_out_if.
module dhf_fill_checker import dhf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dhf_in_if                     pix,
  dhf_out_if                    res,
  output int                    errors,
  output int                    words_due
);

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [DEPTH_W-1:0] depth;
    logic               last;
  } px_word_t;

  // register copies
  logic [FW_W-1:0]    frame_w;
  logic [FH_W-1:0]    frame_h;
  logic [DEPTH_W-1:0] hole_code;
  logic [MINN_W-1:0]  min_valid;

  // row r-2 with final values, row r-1 raw, two columns of the 3x3 window
  logic [DEPTH_W-1:0] done_row [MAX_WIDTH];
  logic [DEPTH_W-1:0] raw_row  [MAX_WIDTH];
  logic [DEPTH_W-1:0] win      [6];
  int unsigned        row_pos;
  int unsigned        col_pos;

  // pixels the block still owes, oldest first
  px_word_t filled_px_q [$];

  initial begin
    foreach (done_row[i]) done_row[i] = '0;
    foreach (raw_row[i]) raw_row[i] = '0;
    foreach (win[i]) win[i] = '0;
  end

  // One raster step: emit (r-1,c-1) once it has its full window, then the
  // border pixel (r,c) if there is one.
  task automatic raster_fill_step(input logic [DEPTH_W-1:0] din);
    int unsigned        w, h, r, c, cnt, sum;
    logic [DEPTH_W-1:0] above2, above1, fv;
    logic [DEPTH_W-1:0] nb [8];
    logic               on_border;
    w = frame_w;
    h = frame_h;
    if (w < MIN_FRAME) w = MIN_FRAME;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < MIN_FRAME) h = MIN_FRAME;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;

    // a geometry shrunk mid-frame pushes the position forward
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;
    on_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);

    above2 = done_row[c];
    above1 = raw_row[c];
    fv = win[3];
    if (r >= 2 && c >= 2) begin
      if (fv == hole_code) begin
        nb = '{win[0], win[1], above2, win[2], above1, win[4], win[5], din};
        cnt = 0;
        sum = 0;
        foreach (nb[i]) begin
          if (nb[i] != hole_code) begin
            cnt++;
            sum += nb[i];
          end
        end
        // no valid neighbor keeps the hole whatever min_valid says
        if (cnt != 0 && cnt >= min_valid) fv = DEPTH_W'(sum / cnt);
      end
      filled_px_q.push_back('{ROW_W'(r - 1), COL_W'(c - 1), fv, !on_border});
    end

    // in-place update: left neighbor becomes final, last column carried over
    if (c >= 1) done_row[c - 1] = fv;
    if (c == w - 1) done_row[c] = above1;
    raw_row[c] = din;
    win[0] = win[1];
    win[1] = above2;
    win[2] = fv;
    win[3] = above1;
    win[4] = win[5];
    win[5] = din;

    if (on_border) filled_px_q.push_back('{ROW_W'(r), COL_W'(c), din, 1'b1});

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic int field_bad(input string name, input int unsigned want,
                                   input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // sample both channels and the register port at each edge
  always @(posedge clk) begin
    int       bad;
    px_word_t want;
    bad = 0;
    if (rst) begin
      frame_w   <= FW_W'(320);
      frame_h   <= FH_W'(240);
      hole_code <= '1;
      min_valid <= MINN_W'(5);
      row_pos = 0;
      col_pos = 0;
      filled_px_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_FRAME_WIDTH:   frame_w   <= cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT:  frame_h   <= cfg_data[FH_W-1:0];
          CFG_HOLE_VALUE:    hole_code <= cfg_data[DEPTH_W-1:0];
          CFG_MIN_NEIGHBORS: min_valid <= cfg_data[MINN_W-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (filled_px_q.size() == 0) begin
          $error("result word with nothing expected: row %0d col %0d depth %0d",
                 res.out_row, res.out_col, res.depth_out);
          bad++;
        end else begin
          want = filled_px_q.pop_front();
          bad += field_bad("out_row", want.row, res.out_row);
          bad += field_bad("out_col", want.col, res.out_col);
          bad += field_bad("depth_out", want.depth, res.depth_out);
          bad += field_bad("last_of_run", want.last, res.last_of_run);
        end
      end
      if (pix.valid && pix.ready) raster_fill_step(pix.depth_in);
      errors <= errors + bad;
    end
    words_due <= filled_px_q.size();
  end

endmodule

// ===== sim/depth_hole_fill_3x3_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for depth_hole_fill_3x3: streams directed and random depth
// frames with random idling, reprograms geometry between frames and gives
// the verdict. Depends on dhf_pkg, the channel interfaces and dhf_fill_checker.
module depth_hole_fill_3x3_tb;
  import dhf_pkg::*;

  localparam int IDLE_PCT     = 7;
  localparam int QUIET_LIMIT  = 5000;
  localparam int SETTLE_TICKS = 20;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [DEPTH_W-1:0] HOLE_MAX = '1;

  // 4x4, hole at full scale: (1,1) sees only holes, the rest mixes extremes
  localparam logic [DEPTH_W-1:0] GRID_4X4 [16] = '{
    HOLE_MAX, HOLE_MAX, HOLE_MAX, 16'd0,
    HOLE_MAX, HOLE_MAX, HOLE_MAX, 16'd65534,
    HOLE_MAX, HOLE_MAX, HOLE_MAX, 16'd1,
    16'd0,    16'd65534, HOLE_MAX, HOLE_MAX
  };
  // 3x3, hole at zero: center filled from eight full-scale neighbors
  localparam logic [DEPTH_W-1:0] GRID_3X3 [9] = '{
    HOLE_MAX, HOLE_MAX, HOLE_MAX,
    HOLE_MAX, 16'd0,    HOLE_MAX,
    HOLE_MAX, HOLE_MAX, HOLE_MAX
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  calm;
  logic [DEPTH_W-1:0]    hole_now;
  int                    errors;
  int                    words_due;
  int                    quiet_cycles = 0;
  int unsigned           sent;

  dhf_in_if  pix_if ();
  dhf_out_if res_if ();

  depth_hole_fill_3x3 i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .pixels   (pix_if),
    .results  (res_if)
  );

  dhf_fill_checker i_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .pix       (pix_if),
    .res       (res_if),
    .errors    (errors),
    .words_due (words_due)
  );

  always #5 clk = ~clk;

  // result back-pressure
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("depth_hole_fill_3x3_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_regs(input int unsigned w, input int unsigned h,
                           input logic [DEPTH_W-1:0] hv, input int unsigned mn);
    put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    put_reg(CFG_HOLE_VALUE, hv);
    put_reg(CFG_MIN_NEIGHBORS, CFG_DATA_W'(mn));
    cfg_we   <= 1'b0;
    hole_now = hv;
  endtask

  // one input word, with random idle cycles ahead of it
  task automatic send_px(input logic [DEPTH_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.depth_in <= v;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // hold input until every owed word is out, then let the pipeline empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  function automatic logic [DEPTH_W-1:0] rand_depth(input int unsigned hole_pct);
    if ($urandom_range(0, 99) < hole_pct) return hole_now;
    case ($urandom_range(0, 3))
      0:       return DEPTH_W'($urandom_range(0, 15));
      1:       return DEPTH_W'($urandom_range(65520, 65535));
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  task automatic send_pixels(input int unsigned n, input int unsigned hole_pct);
    repeat (n) begin
      if ($urandom_range(0, 299) == 0) settle();
      send_px(rand_depth(hole_pct));
    end
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_FRAME) return MIN_FRAME;
    if (v > hi) return hi;
    return v;
  endfunction

  initial begin
    int unsigned        w, h, mn, pct, nf, n;
    logic [DEPTH_W-1:0] hv;
    int                 phase;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_FRAME_WIDTH;
    cfg_data        = '0;
    pix_if.valid    = 1'b0;
    pix_if.depth_in = '0;
    calm            = 1'b0;
    hole_now        = HOLE_MAX;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames
    load_regs(4, 4, HOLE_MAX, 0);
    foreach (GRID_4X4[i]) send_px(GRID_4X4[i]);
    settle();
    load_regs(3, 3, '0, 8);
    foreach (GRID_3X3[i]) send_px(GRID_3X3[i]);
    settle();

    // random frames, new settings between frames
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS || phase < 8) begin
      phase++;
      nf = $urandom_range(1, 2);
      if (phase == 3) begin
        // wide line, height under the minimum, no idling anywhere
        calm <= 1'b1;
        w  = 48;
        h  = 0;
        nf = 1;
      end else if (phase == 6) begin
        // taller frame, narrowest line
        calm <= 1'b0;
        w  = 3;
        h  = 24;
        nf = 1;
      end else begin
        calm <= 1'b0;
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, 2);
          1:       w = $urandom_range(13, 48);
          default: w = $urandom_range(3, 12);
        endcase
        case ($urandom_range(0, 9))
          0:       h = $urandom_range(0, 2);
          1:       h = $urandom_range(9, 24);
          default: h = $urandom_range(3, 8);
        endcase
      end
      case ($urandom_range(0, 4))
        0:       hv = '0;
        1:       hv = HOLE_MAX;
        2:       hv = DEPTH_W'($urandom_range(0, 15));
        default: hv = DEPTH_W'($urandom);
      endcase
      mn  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
      pct = $urandom_range(0, 80);
      n   = nf * clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT);
      load_regs(w, h, hv, mn);
      send_pixels(n, pct);
      settle();
      sent += n;
    end

    // geometry shrunk mid-frame; every buffer entry it reads is written by now
    load_regs(9, 7, DEPTH_W'($urandom), $urandom_range(1, 8));
    send_pixels(51, 30);
    settle();
    put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(4));
    cfg_we <= 1'b0;
    send_pixels(2, 30);
    settle();
    put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    cfg_we <= 1'b0;
    send_pixels(20, 30);
    settle();

    if (errors == 0 && words_due == 0) begin
      $display("depth_hole_fill_3x3_tb passed");
    end else begin
      $display("depth_hole_fill_3x3_tb failed");
    end
    $finish;
  end

endmodule

// ===== depth_hole_fill_3x3.f =====
rtl/dhf_pkg.sv
rtl/dhf_in_if.sv
rtl/dhf_out_if.sv
rtl/dhf_ram.sv
rtl/depth_hole_fill_3x3.sv
sim/dhf_fill_checker.sv
sim/depth_hole_fill_3x3_tb.sv
